@@ hw/rtl/slat_pkg.sv @@
package slat_pkg;

    localparam int unsigned BoardBits  = 64;
    localparam int unsigned SquareBits = 6;
    localparam int unsigned RaySteps   = 7;

    typedef logic [BoardBits-1:0]  board_t;
    typedef logic [SquareBits-1:0] square_t;
    typedef logic signed [1:0]     step_t;

    typedef enum logic
    {
        KIND_ROOK   = 1'b0,
        KIND_BISHOP = 1'b1
    } kind_t;

    // upper and lower rays of the two lines through the origin square
    typedef struct packed
    {
        board_t up0;
        board_t low0;
        board_t up1;
        board_t low1;
    } line_masks_t;

    // squares from sq toward the board edge along (df, dr), origin excluded
    function automatic board_t ray_mask(input square_t sq, input step_t df, input step_t dr);
        logic signed [4:0] f;
        logic signed [4:0] r;
        board_t            m;
        logic              live;
        f    = signed'({2'b00, sq[2:0]});
        r    = signed'({2'b00, sq[5:3]});
        m    = '0;
        live = 1'b1;
        for (int i = 0; i < RaySteps; i++)
        begin
            f = f + {{3{df[1]}}, df};
            r = r + {{3{dr[1]}}, dr};
            if (f < 5'sd0 || f > 5'sd7 || r < 5'sd0 || r > 5'sd7)
            begin
                live = 1'b0;
            end
            if (live)
            begin
                m[{r[2:0], f[2:0]}] = 1'b1;
            end
        end
        return m;
    endfunction

    // ones at and below the highest set bit
    function automatic board_t smear_down(input board_t x);
        board_t s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        s = s | (s >> 32);
        return s;
    endfunction

    // ones at and above the lowest set bit
    function automatic board_t smear_up(input board_t x);
        board_t s;
        s = x;
        s = s | (s << 1);
        s = s | (s << 2);
        s = s | (s << 4);
        s = s | (s << 8);
        s = s | (s << 16);
        s = s | (s << 32);
        return s;
    endfunction

endpackage

@@ hw/rtl/slat_rays.sv @@
module slat_rays
(
    input  logic                 kind,
    input  slat_pkg::square_t    square,
    output slat_pkg::line_masks_t masks
);
    import slat_pkg::*;

    always_comb
    begin
        unique case (kind_t'(kind))
            KIND_ROOK:
            begin
                masks.up0  = ray_mask(square, 2'sd1, 2'sd0);
                masks.low0 = ray_mask(square, -2'sd1, 2'sd0);
                masks.up1  = ray_mask(square, 2'sd0, 2'sd1);
                masks.low1 = ray_mask(square, 2'sd0, -2'sd1);
            end
            KIND_BISHOP:
            begin
                masks.up0  = ray_mask(square, 2'sd1, 2'sd1);
                masks.low0 = ray_mask(square, -2'sd1, -2'sd1);
                masks.up1  = ray_mask(square, -2'sd1, 2'sd1);
                masks.low1 = ray_mask(square, 2'sd1, -2'sd1);
            end
            default:
            begin
                masks = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/slat_line.sv @@
module slat_line
(
    input  slat_pkg::board_t occupancy,
    input  slat_pkg::board_t up_ray,
    input  slat_pkg::board_t low_ray,
    output slat_pkg::board_t attacks
);
    import slat_pkg::*;

    board_t upper;
    board_t lower;
    board_t low_smear;
    board_t up_smear;
    board_t low_fill;
    board_t up_first;
    board_t diff;

    assign upper     = up_ray & occupancy;
    assign lower     = low_ray & occupancy;
    // all ones from the nearest lower blocker (or bit 0) upward
    assign low_smear = smear_down(lower | board_t'(1));
    assign low_fill  = ~(low_smear >> 1);
    // isolate the nearest upper blocker
    assign up_smear  = smear_up(upper);
    assign up_first  = up_smear & ~(up_smear << 1);
    assign diff      = (up_first << 1) + low_fill;
    assign attacks   = (up_ray | low_ray) & diff;

endmodule

@@ hw/rtl/sliding_attack_bitboard.sv @@
// sliding piece attack generator, obstruction difference method
// input channel: in_valid / in_ready carry one query item made of kind
//   (0 rook, 1 bishop), square (rank*8 + file) and the 64-bit occupancy
// output channel: out_valid / out_ready carry the 64-bit attacks set,
//   first blocker on each ray included, empty rays run to the board edge
// flow: an accepted item is captured in the input register, and its
//   result is loaded into the result register when that register is
//   free; out_valid rises once the result register is loaded
// throughput: one item per cycle while out_ready is high; the whole
//   computation (ray masks, blocker isolation and one 64-bit add per
//   line) sits between the input register and the result register
// stall: when out_ready is low the result register holds, the input
//   register holds its item, and in_ready drops only once both are full
// reset: rst_n clears both valid flags; the payload registers are not reset
module sliding_attack_bitboard
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   kind,
    input  slat_pkg::square_t      square,
    input  slat_pkg::board_t       occupancy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output slat_pkg::board_t       attacks
);
    import slat_pkg::*;

    // input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        kind_reg;
    square_t     square_reg;
    board_t      occ_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    board_t      attacks_reg;

    logic        out_free;
    logic        advance;
    logic        in_take;

    line_masks_t masks;
    board_t      line0_attacks;
    board_t      line1_attacks;

    // result register frees when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !out_free);
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind;
            square_reg <= square;
            occ_reg    <= occupancy;
        end
        if (advance)
        begin
            attacks_reg <= line0_attacks | line1_attacks;
        end
    end

    // rank/file or diagonal/anti-diagonal rays of the registered square
    slat_rays u_rays
    (
        .kind   (kind_reg),
        .square (square_reg),
        .masks  (masks)
    );

    slat_line u_line0
    (
        .occupancy (occ_reg),
        .up_ray    (masks.up0),
        .low_ray   (masks.low0),
        .attacks   (line0_attacks)
    );

    slat_line u_line1
    (
        .occupancy (occ_reg),
        .up_ray    (masks.up1),
        .low_ray   (masks.low1),
        .attacks   (line1_attacks)
    );

    assign out_valid = out_valid_reg;
    assign attacks   = attacks_reg;

endmodule
